### src/tte_pkg.sv
// Shared types, constants and helpers for the timestamp text to epoch converter.
package tte_pkg;

  localparam int FIELD_W = 16;
  localparam int NUM_SAVED = 5;

  localparam logic [2:0] FLD_YEAR   = 3'd0;
  localparam logic [2:0] FLD_MONTH  = 3'd1;
  localparam logic [2:0] FLD_DAY    = 3'd2;
  localparam logic [2:0] FLD_HOUR   = 3'd3;
  localparam logic [2:0] FLD_MINUTE = 3'd4;
  localparam logic [2:0] FLD_SECOND = 3'd5;

  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_NINE    = 8'h39;
  localparam logic [7:0] CHAR_DASH    = 8'h2D;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_COLON   = 8'h3A;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

  localparam logic [19:0] FIELD_MAX = 20'd65535;

  // days-from-civil constants
  localparam logic [12:0] YEAR_BIAS   = 13'd4800;
  localparam logic [15:0] MONTH_MUL   = 16'd62719;
  localparam logic [31:0] MONTH_ADD   = 32'd769;
  localparam logic [8:0]  DAYS_YEAR   = 9'd365;
  localparam logic [27:0] DAYS_OFFSET = 28'd2472633;  // 2472632 plus the day-of-month bias
  localparam logic [17:0] RECIP_100   = 18'd167773;   // ceil(2^24 / 100)
  localparam logic signed [17:0] SEC_PER_DAY = 18'sd86400;
  localparam logic [11:0] SEC_PER_HOUR = 12'd3600;
  localparam logic [5:0]  SEC_PER_MIN  = 6'd60;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       end_of_text;
  } tte_in_t;

  typedef struct packed {
    logic signed [42:0] epoch_seconds;
    logic               format_error;
  } tte_out_t;

  typedef struct packed {
    logic [FIELD_W-1:0] year;
    logic [FIELD_W-1:0] month;
    logic [FIELD_W-1:0] day;
    logic [FIELD_W-1:0] hour;
    logic [FIELD_W-1:0] minute;
    logic [FIELD_W-1:0] second;
    logic               err;
  } tte_job_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_DIV,
    BK_MONTH,
    BK_DAYS,
    BK_TOD,
    BK_SCALE,
    BK_SUM
  } tte_back_state_t;

  function automatic logic [7:0] sep_char(input logic [2:0] idx);
    logic [7:0] c;
    unique case (idx)
      FLD_YEAR, FLD_MONTH: c = CHAR_DASH;
      FLD_DAY:             c = CHAR_SPACE;
      FLD_HOUR, FLD_MINUTE: c = CHAR_COLON;
      default:             c = CHAR_NEWLINE;
    endcase
    return c;
  endfunction

endpackage

### src/timestamp_text_to_epoch.sv
// Top level: text timestamp "YYYY-MM-DD HH:MM:SS" in, UNIX epoch seconds out.
//
//   channel  handshake   payload    transfer when
//   input    push/full   item       push && !full
//   result   empty/pop   result     pop && !empty
//
// One byte per cycle is taken while the two-entry job queue has room.
// Each closed timestamp passes through the epoch unit one step at a time
// (/100 reciprocal, month term, day sum, time of day, x86400, final add);
// the unit takes the next job only after it has finished the last one.
// A result waiting for pop holds the epoch unit; the parser keeps going until
// the job queue fills. Synchronous reset clears all control state.
module timestamp_text_to_epoch import tte_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  output logic     full,
  input  tte_in_t  item,
  output logic     empty,
  input  logic     pop,
  output tte_out_t result
);

  logic     accept;
  logic     job_push;
  logic     job_pop;
  logic     job_empty;
  tte_job_t job_in;
  tte_job_t job_head;

  assign accept = push && !full;

  tte_front u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .item     (item),
    .job_push (job_push),
    .job      (job_in)
  );

  tte_jobq u_jobq (
    .clk   (clk),
    .rst   (rst),
    .push  (job_push),
    .din   (job_in),
    .pop   (job_pop),
    .head  (job_head),
    .full  (full),
    .empty (job_empty)
  );

  tte_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_empty (job_empty),
    .job       (job_head),
    .job_pop   (job_pop),
    .pop       (pop),
    .empty     (empty),
    .result    (result)
  );

endmodule

### src/tte_front.sv
// Byte parser: splits timestamp text into fields and queues one job per timestamp.
module tte_front import tte_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     accept,
  input  tte_in_t  item,
  output logic     job_push,
  output tte_job_t job
);

  logic [2:0]         field_index;
  logic [FIELD_W-1:0] digit_accumulator;
  logic               field_bad;
  logic [FIELD_W-1:0] parsed_fields [NUM_SAVED];
  logic               error_seen;
  logic               result_given;

  logic [2:0]         field_index_next;
  logic [FIELD_W-1:0] digit_accumulator_next;
  logic               field_bad_next;
  logic [FIELD_W-1:0] parsed_fields_next [NUM_SAVED];
  logic               error_seen_next;
  logic               result_given_next;

  logic [FIELD_W-1:0] fv;
  logic [FIELD_W-1:0] fv_end;
  logic [19:0]        acc_sum;
  logic               emit;
  logic [FIELD_W-1:0] sec_val;

  assign fv      = field_bad ? '0 : digit_accumulator;
  assign acc_sum = {1'b0, digit_accumulator, 3'b000} + {3'b000, digit_accumulator, 1'b0}
                 + {12'd0, item.char_byte - CHAR_ZERO};

  always_comb begin
    field_index_next       = field_index;
    digit_accumulator_next = digit_accumulator;
    field_bad_next         = field_bad;
    parsed_fields_next     = parsed_fields;
    error_seen_next        = error_seen;
    result_given_next      = result_given;
    emit                   = 1'b0;
    sec_val                = '0;

    if (!result_given) begin
      if (item.char_byte == sep_char(field_index)) begin
        if (field_index != FLD_SECOND) begin
          parsed_fields_next[field_index] = fv;
          field_index_next       = field_index + 3'd1;
          digit_accumulator_next = '0;
          field_bad_next         = 1'b0;
        end else begin
          emit              = 1'b1;
          sec_val           = fv;
          result_given_next = 1'b1;
        end
      end else if (item.char_byte >= CHAR_ZERO && item.char_byte <= CHAR_NINE) begin
        if (acc_sum > FIELD_MAX) begin
          digit_accumulator_next = '1;
          error_seen_next        = 1'b1;
        end else begin
          digit_accumulator_next = acc_sum[FIELD_W-1:0];
        end
      end else begin
        field_bad_next  = 1'b1;
        error_seen_next = 1'b1;
      end
    end

    fv_end = field_bad_next ? '0 : digit_accumulator_next;

    // end of text closes the timestamp; a short one gets its tail zeroed
    if (item.end_of_text && !result_given_next) begin
      emit = 1'b1;
      if (field_index_next != FLD_SECOND) begin
        parsed_fields_next[field_index_next] = fv_end;
        error_seen_next = 1'b1;
        sec_val         = '0;
      end else begin
        sec_val = fv_end;
      end
    end
  end

  assign job_push   = accept && emit;
  assign job.year   = parsed_fields_next[FLD_YEAR];
  assign job.month  = parsed_fields_next[FLD_MONTH];
  assign job.day    = parsed_fields_next[FLD_DAY];
  assign job.hour   = parsed_fields_next[FLD_HOUR];
  assign job.minute = parsed_fields_next[FLD_MINUTE];
  assign job.second = sec_val;
  assign job.err    = error_seen_next;

  always_ff @(posedge clk) begin
    if (rst || (accept && item.end_of_text)) begin
      field_index       <= FLD_YEAR;
      digit_accumulator <= '0;
      field_bad         <= 1'b0;
      for (int i = 0; i < NUM_SAVED; i++) parsed_fields[i] <= '0;
      error_seen        <= 1'b0;
      result_given      <= 1'b0;
    end else if (accept) begin
      field_index       <= field_index_next;
      digit_accumulator <= digit_accumulator_next;
      field_bad         <= field_bad_next;
      parsed_fields     <= parsed_fields_next;
      error_seen        <= error_seen_next;
      result_given      <= result_given_next;
    end
  end

endmodule

### src/tte_jobq.sv
// Two-entry queue of parsed timestamps between the parser and the epoch unit.
module tte_jobq import tte_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  tte_job_t din,
  input  logic     pop,
  output tte_job_t head,
  output logic     full,
  output logic     empty
);

  tte_job_t   entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

### src/tte_back.sv
// Epoch unit: days-from-civil and time of day, computed one step per state.
module tte_back import tte_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     job_empty,
  input  tte_job_t job,
  output logic     job_pop,
  input  logic     pop,
  output logic     empty,
  output tte_out_t result
);

  tte_back_state_t state;
  tte_back_state_t state_next;

  logic [16:0]        ya;
  logic [15:0]        ma;
  logic [15:0]        day;
  logic [15:0]        hour;
  logic [15:0]        minute;
  logic [15:0]        second;
  logic               err;
  logic [9:0]         q100;
  logic [20:0]        md;
  logic signed [27:0] days;
  logic [27:0]        tod;
  logic signed [45:0] scaled;
  logic               out_valid;

  logic               load_out;
  logic               low_month;
  logic [34:0]        div_prod;
  logic [31:0]        month_prod;
  logic [27:0]        days_sum;
  logic [27:0]        tod_sum;

  assign low_month  = (job.month < 16'd3);
  assign div_prod   = ya * RECIP_100;
  assign month_prod = ma * MONTH_MUL + MONTH_ADD;
  // leap term: ya/4 - ya/100 + ya/400, with ya/400 taken as (ya/100)/4
  assign days_sum   = 28'(ya) * 28'(DAYS_YEAR) + 28'(ya >> 2) - 28'(q100) + 28'(q100 >> 2)
                    + 28'(md) + 28'(day) - DAYS_OFFSET;
  assign tod_sum    = 28'(hour) * 28'(SEC_PER_HOUR) + 28'(minute) * 28'(SEC_PER_MIN)
                    + 28'(second);

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE:  if (!job_empty) state_next = BK_DIV;
      BK_DIV:   state_next = BK_MONTH;
      BK_MONTH: state_next = BK_DAYS;
      BK_DAYS:  state_next = BK_TOD;
      BK_TOD:   state_next = BK_SCALE;
      BK_SCALE: state_next = BK_SUM;
      BK_SUM:   if (!out_valid || pop) state_next = BK_IDLE;
      default:  state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    job_pop  = (state == BK_IDLE) && !job_empty;
    load_out = (state == BK_SUM) && (!out_valid || pop);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      ya     <= low_month ? 17'(job.year) + 17'(YEAR_BIAS) - 17'd1
                          : 17'(job.year) + 17'(YEAR_BIAS);
      ma     <= low_month ? job.month + 16'd9 : job.month - 16'd3;
      day    <= job.day;
      hour   <= job.hour;
      minute <= job.minute;
      second <= job.second;
      err    <= job.err;
    end
    if (state == BK_DIV)   q100   <= div_prod[33:24];
    if (state == BK_MONTH) md     <= month_prod[31:11];
    if (state == BK_DAYS)  days   <= $signed(days_sum);
    if (state == BK_TOD)   tod    <= tod_sum;
    if (state == BK_SCALE) scaled <= days * SEC_PER_DAY;
    if (load_out) begin
      result.epoch_seconds <= $signed(scaled[42:0] + 43'(tod));
      result.format_error  <= err;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  assign empty = !out_valid;

endmodule

### src/tte_checker.sv
// Port-level checks for the timestamp converter, bound to the top level.
module tte_checker import tte_pkg::*; (
  input logic     clk,
  input logic     rst,
  input logic     push,
  input logic     full,
  input logic     empty,
  input logic     pop,
  input tte_out_t result
);

  // reset leaves both sides idle
  a_reset_idle: assert property (@(posedge clk) rst |=> (empty && !full))
    else $error("not idle after reset");

  // a result takes every epoch unit step, so none appears shortly after reset
  a_min_latency: assert property (@(posedge clk) rst |=> ##6 empty)
    else $error("result appeared too soon after reset");

  // full only rises right after an input transfer
  a_full_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(full) |-> $past(push && !full))
    else $error("full rose without an input transfer");

  // a waiting result holds until popped
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(result)))
    else $error("waiting result changed or vanished");

endmodule

bind timestamp_text_to_epoch tte_checker u_chk (.*);

### dv/timestamp_text_to_epoch_test.sv
// Self-checking testbench for the timestamp text to epoch seconds converter.
`timescale 1ns / 1ps

import tte_pkg::*;

// Tracks the parser state of the converter and queues the epoch results it should give.
class epoch_scoreboard;
  logic [2:0]         fld;
  logic [FIELD_W-1:0] acc;
  bit                 bad;
  logic [FIELD_W-1:0] saved [NUM_SAVED];
  bit                 err;
  bit                 done;
  tte_out_t           pending [$];
  int                 errors;

  function new();
    errors = 0;
    clear();
  endfunction

  function void clear();
    fld = FLD_YEAR;
    acc = '0;
    bad = 1'b0;
    foreach (saved[i]) saved[i] = '0;
    err = 1'b0;
    done = 1'b0;
  endfunction

  // March-based day count, then time of day on top
  function tte_out_t epoch_of(logic [FIELD_W-1:0] sec);
    longint unsigned ya, ma, md, leap;
    longint days, secs;
    tte_out_t r;
    if (saved[FLD_MONTH] < 3) begin
      ma = saved[FLD_MONTH] + 9;
      ya = saved[FLD_YEAR] + 4800 - 1;
    end else begin
      ma = saved[FLD_MONTH] - 3;
      ya = saved[FLD_YEAR] + 4800;
    end
    md = (ma * 62719 + 769) / 2048;
    leap = ya / 4 - ya / 100 + ya / 400;
    days = longint'(ya * 365 + leap + md) + longint'(saved[FLD_DAY]) - 1 - 2472632;
    secs = 86400 * days + longint'(saved[FLD_HOUR]) * 3600
         + longint'(saved[FLD_MINUTE]) * 60 + longint'(sec);
    r.epoch_seconds = secs[42:0];
    r.format_error = err;
    done = 1'b1;
    return r;
  endfunction

  function void note_byte(tte_in_t it);
    logic [7:0]  term;
    logic [31:0] v;
    if (!done) begin
      case (fld)
        FLD_YEAR, FLD_MONTH:   term = CHAR_DASH;
        FLD_DAY:               term = CHAR_SPACE;
        FLD_HOUR, FLD_MINUTE:  term = CHAR_COLON;
        default:               term = CHAR_NEWLINE;
      endcase
      if (it.char_byte == term) begin
        if (fld != FLD_SECOND) begin
          saved[fld] = bad ? '0 : acc;
          fld = fld + 3'd1;
          acc = '0;
          bad = 1'b0;
        end else begin
          pending.push_back(epoch_of(bad ? '0 : acc));
        end
      end else if (it.char_byte >= CHAR_ZERO && it.char_byte <= CHAR_NINE) begin
        v = acc * 10 + (it.char_byte - CHAR_ZERO);
        if (v > 65535) begin
          v = 65535;
          err = 1'b1;
        end
        acc = v[FIELD_W-1:0];
      end else begin
        bad = 1'b1;
        err = 1'b1;
      end
    end
    if (it.end_of_text) begin
      if (!done) begin
        if (fld != FLD_SECOND) begin
          // text ended early: close the open field, zero the rest
          saved[fld] = bad ? '0 : acc;
          for (int k = fld + 1; k < NUM_SAVED; k++) saved[k] = '0;
          err = 1'b1;
          pending.push_back(epoch_of('0));
        end else begin
          pending.push_back(epoch_of(bad ? '0 : acc));
        end
      end
      clear();
    end
  endfunction

  function void check_result(tte_out_t got);
    tte_out_t want;
    if (pending.size() == 0) begin
      $display("%0t: unexpected result epoch %0d error %0b", $time,
               got.epoch_seconds, got.format_error);
      errors++;
      return;
    end
    want = pending.pop_front();
    if (got.epoch_seconds !== want.epoch_seconds) begin
      $display("%0t: epoch_seconds expected %0d actual %0d", $time,
               want.epoch_seconds, got.epoch_seconds);
      errors++;
    end
    if (got.format_error !== want.format_error) begin
      $display("%0t: format_error expected %0b actual %0b", $time,
               want.format_error, got.format_error);
      errors++;
    end
  endfunction
endclass

module timestamp_text_to_epoch_test;

  localparam int STALL_LIMIT = 2000;
  localparam int BYTE_TARGET = 1750;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     push = 1'b0;
  logic     full;
  tte_in_t  item = '0;
  logic     empty;
  logic     pop = 1'b0;
  tte_out_t result;

  epoch_scoreboard sb;
  logic [7:0]      text_q [$];
  int              bytes_sent = 0;
  int              idle_cycles = 0;
  bit              calm = 1'b0;

  timestamp_text_to_epoch dut (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .item   (item),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

  always #6 clk = ~clk;

  // mostly short gaps, now and then a long one; none at all while calm
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic string rand_field(int lo, int hi, bit wide);
    int v;
    int r;
    r = $urandom_range(0, 9);
    if (r == 7) return $sformatf("%0d", $urandom_range(0, 65535));
    if (r == 8) return $sformatf("%0d", $urandom_range(0, 999999));
    if (r == 9) return "";
    v = $urandom_range(lo, hi);
    if ($urandom_range(0, 1)) return wide ? $sformatf("%04d", v) : $sformatf("%02d", v);
    return $sformatf("%0d", v);
  endfunction

  function automatic void add_str(string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endfunction

  task automatic send_byte(logic [7:0] c, bit last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    push <= 1'b1;
    item <= '{char_byte: c, end_of_text: last};
    @(posedge clk);
    while (full) @(posedge clk);
    @(negedge clk);
  endtask

  // sends the buffered text, marking its final byte as end of text
  task automatic send_text();
    if (text_q.size() == 0) text_q.push_back(8'($urandom_range(0, 255)));
    foreach (text_q[i]) send_byte(text_q[i], i == text_q.size() - 1);
    bytes_sent += text_q.size();
    text_q.delete();
  endtask

  task automatic drain();
    push <= 1'b0;
    @(negedge clk);
    while (sb.pending.size() != 0) @(negedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (push && !full) sb.note_byte(item);
      if (pop && !empty) sb.check_result(result);
      if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    while (idle_cycles < STALL_LIMIT) @(posedge clk);
    $display("== FAIL ==");
    $finish;
  end

  // result side: bursts of pop with random holds in between
  initial begin
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      pop <= 1'b1;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
  end

  initial begin
    int n;
    int pos;
    bit paused;
    paused = 1'b0;
    sb = new();
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed cases
    add_str("1970-01-01 00:00:00\n"); send_text();
    add_str("65535-65535-65535 65535:65535:65535\n"); send_text();
    add_str("0-0-0 0:0:0\n"); send_text();
    add_str("2000-02-29 23:59:59\n"); send_text();
    add_str("123456-1-1 0:0:99999\n"); send_text();
    add_str("2024-0a-15 10:20:30\n"); send_text();
    add_str("-- ::\n"); send_text();
    add_str("2024-03"); send_text();
    add_str("2024-03-01 12:34:56"); send_text();
    add_str("1999-12-31 23:59:59\nAB"); send_text();
    text_q.push_back(8'h00); send_text();
    text_q.push_back(8'hFF); send_text();
    drain();

    while (bytes_sent < BYTE_TARGET) begin
      calm = ($urandom_range(0, 4) == 0);
      add_str({rand_field(1900, 2100, 1'b1), "-", rand_field(1, 12, 1'b0), "-",
               rand_field(1, 31, 1'b0), " ", rand_field(0, 23, 1'b0), ":",
               rand_field(0, 59, 1'b0), ":", rand_field(0, 59, 1'b0)});
      n = $urandom_range(0, 9);
      if (n < 6) begin
        text_q.push_back(CHAR_NEWLINE);
      end else if (n < 8) begin
        text_q.push_back(CHAR_NEWLINE);
        repeat ($urandom_range(1, 4)) text_q.push_back(8'($urandom_range(0, 255)));
      end
      // about a third of the timestamps get broken
      if ($urandom_range(0, 9) < 3) begin
        pos = $urandom_range(0, text_q.size() - 1);
        case ($urandom_range(0, 3))
          0: text_q[pos] = 8'($urandom_range(0, 255));
          1: begin
            n = $urandom_range(1, text_q.size());
            while (text_q.size() > n) void'(text_q.pop_back());
          end
          2: begin
            case ($urandom_range(0, 3))
              0:       text_q[pos] = CHAR_DASH;
              1:       text_q[pos] = CHAR_SPACE;
              2:       text_q[pos] = CHAR_COLON;
              default: text_q[pos] = CHAR_NEWLINE;
            endcase
          end
          default: begin
            text_q.delete();
            repeat ($urandom_range(1, 24)) text_q.push_back(8'($urandom_range(0, 255)));
          end
        endcase
      end
      send_text();
      if (!paused && bytes_sent > BYTE_TARGET / 2) begin
        drain();
        paused = 1'b1;
      end
    end
    push <= 1'b0;
    calm = 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
